// ===== design/egbr_pkg.sv =====
// Shared constants, opcodes and state codes for the Exp-Golomb bitstream reader.
package egbr_pkg;

  localparam int BUFFER_BYTES   = 4096;
  localparam int ADDR_W         = $clog2(BUFFER_BYTES);
  localparam int COUNT_W        = 13;
  localparam int POS_W          = 16;
  localparam int NBITS_W        = 6;
  localparam int USED_W         = 6;
  localparam int VALUE_W        = 33;
  localparam int MAX_FIXED_BITS = 32;
  localparam int MAX_PREFIX     = 31;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_SEEK  = 3'd1,
    OP_READU = 3'd2,
    OP_READI = 3'd3,
    OP_UE    = 3'd4,
    OP_SE    = 3'd5,
    OP_QUERY = 3'd6
  } opcode_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREFIX = 5'b00010,
    S_FIELD  = 5'b00100,
    S_QUERY  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

endpackage

// ===== design/egbr_buffer.sv =====
// Payload byte store: one write port, one registered read port.
module egbr_buffer
  import egbr_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [BUFFER_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/exp_golomb_bitstream_reader.sv =====
// Top level: RBSP bitstream reader with fixed-length and Exp-Golomb field decoding.
// One item at a time; a single bit extractor walks the buffer one bit per cycle,
// pausing whenever a new byte must be fetched from the buffer memory (registered read).
// Load, seek and most queries go straight to S_DONE; a query on the last byte first reads it.
// Fixed reads shift in S_FIELD; ue/se count zeros in S_PREFIX, then read info bits in S_FIELD.
// Synchronous active-high reset clears position, byte_count and control; buffer is not cleared.
module exp_golomb_bitstream_reader
  import egbr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [COUNT_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                opcode,
  input  logic [ADDR_W-1:0]         byte_address,
  input  logic [7:0]                byte_value,
  input  logic [NBITS_W-1:0]        bit_count,
  input  logic [POS_W-1:0]          new_bit_position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] value,
  output logic [USED_W-1:0]         bits_used,
  output logic                      status,
  output logic                      more_data
);

  state_t               state;
  logic [COUNT_W-1:0]   byte_count;
  logic [POS_W-1:0]     bit_position;
  logic [POS_W-1:0]     scan_pos;
  logic                 byte_ok;
  logic [2:0]           op;
  logic                 sign_first;
  logic [NBITS_W-1:0]   zeros;
  logic [NBITS_W-1:0]   bits_left;
  logic [VALUE_W-1:0]   acc;
  logic [USED_W-1:0]    used;
  logic                 err;
  logic                 more;

  logic [7:0]           rd_data;
  logic                 accept;
  logic                 out_free;
  logic [COUNT_W-1:0]   valid_bytes;
  logic [POS_W-1:0]     end_bits;
  logic                 cur_bit;
  logic [POS_W:0]       fixed_end;
  logic [POS_W:0]       eg_end;
  logic [COUNT_W-1:0]   byte_idx;
  logic [VALUE_W-1:0]   mapped;
  logic [VALUE_W-1:0]   mag;
  logic [POS_W-1:0]     pos_inc;
  logic                 same_byte;
  logic                 is_fixed;
  logic                 fixed_bad;
  logic                 in_data;
  logic                 last_byte;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign valid_bytes = (byte_count > COUNT_W'(BUFFER_BYTES)) ? COUNT_W'(BUFFER_BYTES)
                                                             : byte_count;
  assign end_bits    = {valid_bytes, 3'b000};
  assign cur_bit     = rd_data[~scan_pos[2:0]];
  assign fixed_end   = {1'b0, bit_position} + (POS_W+1)'(bit_count);
  assign eg_end      = {1'b0, scan_pos} + (POS_W+1)'(zeros) + (POS_W+1)'(1);
  assign byte_idx    = bit_position[POS_W-1:3];
  assign pos_inc     = scan_pos + POS_W'(1);
  assign same_byte   = (scan_pos[2:0] != 3'b111);
  assign is_fixed    = (opcode == OP_READU) || (opcode == OP_READI);
  assign fixed_bad   = (bit_count > NBITS_W'(MAX_FIXED_BITS)) || (fixed_end > {1'b0, end_bits});
  assign in_data     = (byte_idx < valid_bytes);
  assign last_byte   = ((byte_idx + COUNT_W'(1)) >= valid_bytes);

  egbr_buffer u_buffer (
    .clk     (clk),
    .wr_en   (accept && (opcode == OP_LOAD)),
    .wr_addr (byte_address),
    .wr_data (byte_value),
    .rd_addr (scan_pos[ADDR_W+2:3]),
    .rd_data (rd_data)
  );

  // map the collected bits to the final value: acc holds 1<<zeros | info for Exp-Golomb
  always_comb begin
    mag = {1'b0, acc[VALUE_W-1:1]};
    case (op)
      OP_UE:   mapped = acc - VALUE_W'(1);
      OP_SE:   mapped = acc[0] ? (VALUE_W'(0) - mag) : mag;
      default: mapped = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      byte_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bit_position <= '0;
      out_valid    <= 1'b0;
    end else begin
      // a result leaving while the next one is ready is replaced in S_DONE
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= opcode;
            scan_pos   <= bit_position;
            byte_ok    <= 1'b0;
            acc        <= '0;
            zeros      <= '0;
            bits_left  <= bit_count;
            sign_first <= (opcode == OP_READI);
            err        <= is_fixed && fixed_bad;
            used       <= (is_fixed && !fixed_bad) ? USED_W'(bit_count) : '0;
            more       <= (opcode == OP_QUERY) && in_data && !last_byte;
            case (opcode)
              OP_SEEK: begin
                bit_position <= new_bit_position;
                state        <= S_DONE;
              end
              OP_READU, OP_READI: begin
                state <= (fixed_bad || bit_count == '0) ? S_DONE : S_FIELD;
              end
              OP_UE, OP_SE: begin
                state <= S_PREFIX;
              end
              OP_QUERY: begin
                // only the last byte needs a look at the bits
                state <= (in_data && last_byte) ? S_QUERY : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_PREFIX: begin
          if (zeros == NBITS_W'(MAX_PREFIX + 1) || scan_pos >= end_bits) begin
            err   <= 1'b1;
            state <= S_DONE;
          end else if (!byte_ok) begin
            byte_ok <= 1'b1;
          end else if (!cur_bit) begin
            zeros    <= zeros + NBITS_W'(1);
            scan_pos <= pos_inc;
            byte_ok  <= same_byte;
          end else if (eg_end > {1'b0, end_bits}) begin
            err   <= 1'b1;
            state <= S_DONE;
          end else begin
            // leading one found: info bits follow
            acc       <= VALUE_W'(1);
            used      <= {zeros[USED_W-2:0], 1'b1};
            bits_left <= zeros;
            scan_pos  <= pos_inc;
            byte_ok   <= same_byte;
            if (zeros == '0) begin
              bit_position <= pos_inc;
              state        <= S_DONE;
            end else begin
              state <= S_FIELD;
            end
          end
        end

        S_FIELD: begin
          if (!byte_ok) begin
            byte_ok <= 1'b1;
          end else begin
            // a signed field starts from its sign bit replicated
            acc        <= sign_first ? {VALUE_W{cur_bit}} : {acc[VALUE_W-2:0], cur_bit};
            sign_first <= 1'b0;
            bits_left  <= bits_left - NBITS_W'(1);
            scan_pos   <= pos_inc;
            byte_ok    <= same_byte;
            if (bits_left == NBITS_W'(1)) begin
              bit_position <= pos_inc;
              state        <= S_DONE;
            end
          end
        end

        S_QUERY: begin
          if (!byte_ok) begin
            byte_ok <= 1'b1;
          end else begin
            more  <= !cur_bit || ((rd_data & (8'h7F >> scan_pos[2:0])) != 8'h00);
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload: no reset needed
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      value     <= err ? '0 : mapped;
      bits_used <= err ? '0 : used;
      status    <= err;
      more_data <= more;
    end
  end

endmodule
